// ===== design/cbp_pkg.sv =====
// ----------------------------------------------------------------------------
// cbp_pkg: shared types and constants for the coupon bond pricer
// Transaction structs, controller commands and status, and fixed constants.
// ----------------------------------------------------------------------------
package cbp_pkg;

  localparam int DefMaxYears = 32;

  localparam logic [29:0] ShiftReset = 30'd107374;
  localparam logic [47:0] PriceMax   = 48'hFFFF_FFFF_FFFF;
  localparam logic [48:0] FaceQ24    = 49'd100 << 24;
  localparam int          DivSteps   = 63;

  localparam logic [1:0] StatOk      = 2'd0;
  localparam logic [1:0] StatBadBase = 2'd1;
  localparam logic [1:0] StatSat     = 2'd2;

  localparam logic [1:0] YldBase = 2'd0;
  localparam logic [1:0] YldUp   = 2'd1;
  localparam logic [1:0] YldDown = 2'd2;

  typedef struct packed {
    logic        [31:0] bond_tag;
    logic signed [31:0] annual_yield;
    logic        [30:0] coupon_rate;
    logic        [5:0]  years_left;
  } in_t;

  typedef struct packed {
    logic        [31:0] tag_out;
    logic signed [31:0] yield_out;
    logic        [30:0] coupon_out;
    logic        [5:0]  years_out;
    logic        [47:0] base_price;
    logic        [47:0] price_up;
    logic        [47:0] price_down;
    logic        [1:0]  status;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_BASE, ST_CHECK, ST_DIV, ST_ADD, ST_MUL, ST_STORE, ST_FINISH
  } state_t;

  typedef struct packed {
    logic       load_in;
    logic       ld_base;
    logic       div_step;
    logic       horner_add;
    logic       mul_step;
    logic       mul_fin;
    logic       store_price;
    logic       out_load;
    logic [1:0] yidx;
    logic [5:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic skip;      // no periods or non-positive base
    logic sat;       // accumulator saturated
    logic mul_sat;   // product of the current multiply saturates
    logic k_last;    // current period is the first one
    logic out_busy;  // output register holds an untaken result
  } stat_t;

endpackage

// ===== design/cbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbp_ctrl: sequencing controller
// Steps each bond through base set-up, reciprocal division and the Horner
// loop for the three yields, then hands the result to the output register.
// ----------------------------------------------------------------------------
module cbp_ctrl import cbp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t     state, state_next;
  logic [1:0] yidx, yidx_next;
  logic [5:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      yidx  <= YldBase;
      cnt   <= '0;
    end else begin
      state <= state_next;
      yidx  <= yidx_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    yidx_next  = yidx;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_BASE;
          yidx_next  = YldBase;
        end
      end
      ST_BASE:  state_next = ST_CHECK;
      ST_CHECK: begin
        cnt_next   = '0;
        state_next = st.skip ? ST_STORE : ST_DIV;
      end
      ST_DIV: begin
        cnt_next = cnt + 6'd1;
        if (cnt == 6'(DivSteps - 1)) state_next = ST_ADD;
      end
      ST_ADD: begin
        cnt_next   = '0;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        cnt_next = cnt + 6'd1;
        if (cnt == 6'd0 && st.sat) begin
          state_next = ST_STORE;
        end else if (cnt == 6'd4) begin
          state_next = (st.mul_sat || st.k_last) ? ST_STORE : ST_ADD;
        end
      end
      ST_STORE: begin
        if (yidx == YldDown) begin
          state_next = ST_FINISH;
        end else begin
          yidx_next  = yidx + 2'd1;
          state_next = ST_BASE;
        end
      end
      ST_FINISH: begin
        if (!st.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.yidx = yidx;
    cmd.cnt  = cnt;
    in_stall = (state != ST_IDLE);
    case (state)
      ST_IDLE:   cmd.load_in = in_valid;
      ST_BASE:   cmd.ld_base = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_ADD:    cmd.horner_add = 1'b1;
      ST_MUL: begin
        if (cnt == 6'd4) cmd.mul_fin = 1'b1;
        else if (!(cnt == 6'd0 && st.sat)) cmd.mul_step = 1'b1;
      end
      ST_STORE:  cmd.store_price = 1'b1;
      ST_FINISH: cmd.out_load = !st.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== design/cbp_dp.sv =====
// ----------------------------------------------------------------------------
// cbp_dp: pricing datapath
// Holds the bond, the compounding base, a restoring reciprocal divider, a
// shared 32x32 multiplier for the Horner steps and the output register.
// ----------------------------------------------------------------------------
module cbp_dp import cbp_pkg::*; #(
  parameter int MAX_YEARS = DefMaxYears
) (
  input  logic        clk,
  input  logic        rst,
  input  in_t         in_data,
  input  logic [29:0] shift,
  input  cmd_t        cmd,
  output stat_t       st,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  localparam int PW = $clog2(2 * MAX_YEARS + 1);

  in_t                bond;
  logic        [PW-1:0] periods, k;
  logic        [31:0] cpn;
  logic        [32:0] b;
  logic               bad, s;
  logic        [32:0] rem;
  logic        [62:0] q;
  logic        [47:0] acc;
  logic        [63:0] prod;
  logic        [1:0]  psel;
  logic        [79:0] msum;
  logic        [47:0] price [3];
  logic               bad_any, sat_any;

  // Bond set-up from the input transaction.
  logic [7:0]    yrs;
  logic          semi;
  logic          semi_r;
  logic [PW-1:0] per_in;
  logic [37:0]   cpn_full;
  always_comb begin
    yrs      = ({2'b0, in_data.years_left} > 8'(MAX_YEARS)) ? 8'(MAX_YEARS)
                                                            : {2'b0, in_data.years_left};
    semi     = (yrs > 8'd1);
    per_in   = semi ? PW'({yrs, 1'b0}) : PW'(yrs);
    cpn_full = 38'(in_data.coupon_rate) * 38'd100;
  end

  // Compounding base for the selected yield, truncating the halving to zero.
  logic signed [33:0] ys, half, bnew;
  always_comb begin
    case (cmd.yidx)
      YldUp:   ys = 34'(bond.annual_yield) + $signed({4'b0, shift});
      YldDown: ys = 34'(bond.annual_yield) - $signed({4'b0, shift});
      default: ys = 34'(bond.annual_yield);
    endcase
    half = (periods > PW'(2) || (periods == PW'(2) && semi_r)) ?
           ($signed(ys + 34'(ys[33])) >>> 1) : ys;
    bnew = 34'sd1073741824 + half;
  end

  // Restoring division step of 2^62 by b.
  logic [33:0] rn, rdiff;
  always_comb begin
    rn    = {rem, (cmd.cnt == 6'd0)};
    rdiff = rn - {1'b0, b};
  end

  // Horner add and multiply accumulate.
  logic [48:0] asum;
  logic [31:0] opa, opb;
  logic [79:0] wprod, mtot;
  always_comb begin
    asum  = {1'b0, acc} + 49'(cpn) + ((k == periods) ? FaceQ24 : 49'd0);
    opa   = cmd.cnt[0] ? {16'b0, acc[47:32]} : acc[31:0];
    opb   = cmd.cnt[1] ? {1'b0, q[62:32]} : q[31:0];
    case (psel)
      2'd0:    wprod = 80'(prod[63:32]);
      2'd3:    wprod = {prod[47:0], 32'b0};
      default: wprod = 80'(prod);
    endcase
    mtot = msum + wprod;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      bond    <= in_data;
      periods <= per_in;
      semi_r  <= semi;
      cpn     <= semi ? cpn_full[38-1:6] >> 1 : 32'(cpn_full[37:6]);
      bad_any <= 1'b0;
      sat_any <= 1'b0;
    end
    if (cmd.ld_base) begin
      bad <= (bnew <= 0);
      b   <= bnew[32:0];
      rem <= '0;
      acc <= '0;
      s   <= 1'b0;
      k   <= periods;
    end
    if (cmd.div_step) begin
      if (!rdiff[33]) begin
        rem <= rdiff[32:0];
        q   <= {q[61:0], 1'b1};
      end else begin
        rem <= rn[32:0];
        q   <= {q[61:0], 1'b0};
      end
    end
    if (cmd.horner_add) begin
      if (asum > {1'b0, PriceMax}) begin
        acc <= PriceMax;
        s   <= 1'b1;
      end else begin
        acc <= asum[47:0];
      end
    end
    if (cmd.mul_step) begin
      prod <= 64'(opa) * 64'(opb);
      psel <= cmd.cnt[1:0];
      msum <= (cmd.cnt == 6'd0) ? '0 : mtot;
    end
    if (cmd.mul_fin) begin
      k <= k - PW'(1);
      if (mtot > 80'(PriceMax)) begin
        acc <= PriceMax;
        s   <= 1'b1;
      end else begin
        acc <= mtot[47:0];
      end
    end
    if (cmd.store_price) begin
      price[cmd.yidx] <= bad ? 48'd0 : (s ? PriceMax : acc);
      if (periods != '0) begin
        bad_any <= bad_any | bad;
        sat_any <= sat_any | (s & !bad);
      end
    end
  end

  // Output register: one result waits here while the next bond is priced.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.tag_out    <= bond.bond_tag;
      out_data.yield_out  <= bond.annual_yield;
      out_data.coupon_out <= bond.coupon_rate;
      out_data.years_out  <= bond.years_left;
      out_data.base_price <= price[YldBase];
      out_data.price_up   <= price[YldUp];
      out_data.price_down <= price[YldDown];
      out_data.status     <= bad_any ? StatBadBase : (sat_any ? StatSat : StatOk);
    end
  end

  always_comb begin
    st.skip     = (periods == '0) || bad;
    st.sat      = s;
    st.mul_sat  = (mtot > 80'(PriceMax));
    st.k_last   = (k == PW'(1));
    st.out_busy = out_valid && out_stall;
  end

endmodule

// ===== design/coupon_bond_price_with_yield_shift.sv =====
// ----------------------------------------------------------------------------
// coupon_bond_price_with_yield_shift: coupon bond pricer with yield shift
// Prices each bond at its yield and at the yield plus and minus a shift.
// ----------------------------------------------------------------------------
// One bond is priced at a time. For each of the three yields the block forms
// the compounding base, checks it, runs the restoring reciprocal division
// and stores the price. Between the division and the store, each coupon
// period takes a Horner add and the four partial products of the shared
// 32x32 multiplier. A zero maturity or a non-positive base skips the division
// and the loop for that yield, and a saturated price ends its loop early.
// The result waits in an output register while the next bond is taken; a
// stalled result holds the block until it leaves. The yield shift register
// may be written at any time the block is idle.
module coupon_bond_price_with_yield_shift import cbp_pkg::*; #(
  parameter int MAX_YEARS = DefMaxYears
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [29:0] cfg_data
);

  logic [29:0] yield_shift;
  cmd_t        cmd;
  stat_t       st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      yield_shift <= ShiftReset;
    end else if (cfg_valid) begin
      yield_shift <= cfg_data;
    end
  end

  cbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  cbp_dp #(.MAX_YEARS(MAX_YEARS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .shift     (yield_shift),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
